>>> rtl/core/szp_pkg.sv
// Package with the phase and radix types and character codes for the size string parser.
package szp_pkg;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SUFFIX = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_F    = 8'h46;
    localparam logic [7:0] CH_LC_X    = 8'h78;
    localparam logic [7:0] CH_UC_X    = 8'h58;
    localparam logic [7:0] CH_LC_K    = 8'h6B;
    localparam logic [7:0] CH_UC_K    = 8'h4B;
    localparam logic [7:0] CH_LC_M    = 8'h6D;
    localparam logic [7:0] CH_UC_M    = 8'h4D;

    localparam int unsigned KILO_SHIFT = 10;
    localparam int unsigned MEGA_SHIFT = 20;

endpackage

>>> rtl/core/size_string_parser.sv
// Streaming integer parser with radix prefix and kilo/mega suffix scaling.
// A result is written to the result register once its terminating item has passed from the input register.
// Throughput: one item per cycle while the output side takes results without stalling.
// The limit is the single registered pass from the input register to the result register.
// Reset clears the phase to done, the radix to decimal, the accumulator and all valid flags.
// After reset, characters are ignored until an item with start_req set arrives.
module size_string_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             ch,
    input  logic                   start_req,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] value
);
    import szp_pkg::*;

    logic                   in_vld_reg;
    logic [7:0]             ch_reg;
    logic                   start_reg;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    radix_t                 radix_reg;
    radix_t                 radix_next;
    logic [VALUE_WIDTH-1:0] accum_reg;
    logic [VALUE_WIDTH-1:0] accum_next;
    logic                   out_vld_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   advance;
    logic                   emit;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign value     = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
        end
    end

    always_comb
    begin
        logic                   eval;
        logic                   is_dec;
        logic                   is_hex_lc;
        logic                   is_hex_uc;
        logic                   is_digit;
        logic [3:0]             digit;
        logic [VALUE_WIDTH-1:0] scaled;

        phase_next = phase_reg;
        radix_next = radix_reg;
        accum_next = accum_reg;
        emit       = 1'b0;
        eval       = 1'b1;

        if (start_reg)
        begin
            accum_next = '0;
            if (ch_reg == CH_ZERO)
            begin
                radix_next = RX_OCT;
                phase_next = PH_LEAD;
                eval       = 1'b0;
            end
            else
            begin
                radix_next = RX_DEC;
                phase_next = PH_DIGITS;
            end
        end
        else if (phase_reg == PH_DONE)
        begin
            eval = 1'b0;
        end
        else if (phase_reg == PH_LEAD)
        begin
            phase_next = PH_DIGITS;
            if (ch_reg == CH_LC_X || ch_reg == CH_UC_X)
            begin
                radix_next = RX_HEX;
                eval       = 1'b0;
            end
        end

        is_dec    = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        is_hex_lc = (radix_next == RX_HEX) && (ch_reg >= CH_LC_A) && (ch_reg <= CH_LC_F);
        is_hex_uc = (radix_next == RX_HEX) && (ch_reg >= CH_UC_A) && (ch_reg <= CH_UC_F);
        is_digit  = is_dec || is_hex_lc || is_hex_uc;

        if (is_dec)
        begin
            digit = 4'(ch_reg - CH_ZERO);
        end
        else if (is_hex_lc)
        begin
            digit = 4'(ch_reg - CH_LC_A + 8'd10);
        end
        else
        begin
            digit = 4'(ch_reg - CH_UC_A + 8'd10);
        end

        unique case (radix_next)
            RX_HEX:  scaled = accum_next << 4;
            RX_OCT:  scaled = accum_next << 3;
            default: scaled = (accum_next << 3) + (accum_next << 1);
        endcase

        if (eval)
        begin
            if (phase_next == PH_DIGITS && is_digit)
            begin
                accum_next = scaled + VALUE_WIDTH'(digit);
            end
            else
            begin
                phase_next = PH_SUFFIX;
                if (ch_reg == CH_LC_K || ch_reg == CH_UC_K)
                begin
                    accum_next = accum_next << KILO_SHIFT;
                end
                else if (ch_reg == CH_LC_M || ch_reg == CH_UC_M)
                begin
                    accum_next = accum_next << MEGA_SHIFT;
                end
                else
                begin
                    phase_next = PH_DONE;
                    emit       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            radix_reg <= RX_DEC;
            accum_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            value_reg <= accum_next;
        end
    end

    // A new result only ever follows a terminating item that left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(advance && emit))
        else $error("Result raised without a terminating item");

    // Emitting a result always closes the parse.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> phase_reg == PH_DONE)
        else $error("Phase not done after a result");

    // A leading zero has contributed nothing to the accumulator yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEAD |-> accum_reg == '0)
        else $error("Accumulator not clear after a leading zero");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the size string parser, with a scoreboard class that predicts each value.
module testbench;

    import szp_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [63:0] BASE_DEC = 64'd10;
    localparam logic [63:0] BASE_OCT = 64'd8;
    localparam logic [63:0] BASE_HEX = 64'd16;

    class parsed_size_scoreboard;
        phase_t phase;
        radix_t radix;
        logic [63:0] accum;
        logic [63:0] pending_sizes[$];
        int errors;

        function new();
            phase = PH_DONE;
            radix = RX_DEC;
            accum = '0;
            errors = 0;
        endfunction

        function void take_char(logic [7:0] c, logic s);
            int digit;
            logic [63:0] base;
            if (s)
            begin
                accum = '0;
                if (c == CH_ZERO)
                begin
                    radix = RX_OCT;
                    phase = PH_LEAD;
                    return;
                end
                radix = RX_DEC;
                phase = PH_DIGITS;
            end
            else if (phase == PH_DONE)
            begin
                return;
            end
            else if (phase == PH_LEAD)
            begin
                phase = PH_DIGITS;
                if (c == CH_LC_X || c == CH_UC_X)
                begin
                    radix = RX_HEX;
                    return;
                end
            end
            if (phase == PH_DIGITS)
            begin
                digit = -1;
                if (c >= CH_ZERO && c <= CH_NINE)
                    digit = int'(c - CH_ZERO);
                else if (radix == RX_HEX && c >= CH_LC_A && c <= CH_LC_F)
                    digit = int'(c - CH_LC_A) + 10;
                else if (radix == RX_HEX && c >= CH_UC_A && c <= CH_UC_F)
                    digit = int'(c - CH_UC_A) + 10;
                if (digit >= 0)
                begin
                    base = (radix == RX_HEX) ? BASE_HEX : (radix == RX_OCT) ? BASE_OCT : BASE_DEC;
                    accum = accum * base + 64'(digit);
                    return;
                end
                phase = PH_SUFFIX;
            end
            if (c == CH_UC_K || c == CH_LC_K)
            begin
                accum = accum << KILO_SHIFT;
                return;
            end
            if (c == CH_UC_M || c == CH_LC_M)
            begin
                accum = accum << MEGA_SHIFT;
                return;
            end
            phase = PH_DONE;
            pending_sizes.push_back(accum);
        endfunction

        function void check_size(logic [63:0] got);
            logic [63:0] want;
            if (pending_sizes.size() == 0)
            begin
                $display("%0t: value with none expected, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_sizes.pop_front();
            if (got !== want)
            begin
                $display("%0t: value mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = '0;
    logic        start_req = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] value;

    parsed_size_scoreboard sb;
    int parsed_chars = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_request = 1'b0;

    size_string_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_size(value);
            if (in_valid && in_ready)
                sb.take_char(ch, start_req);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rst_n)
                out_ready <= !(rx_idle_en && $urandom_range(0, 99) < 12);
        end
    end

    initial
    begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("FAIL size_string_parser");
        $finish;
    end

    function automatic bit continues_parse(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F)
            || (c >= CH_UC_A && c <= CH_UC_F) || c == CH_LC_K || c == CH_UC_K
            || c == CH_LC_M || c == CH_UC_M || c == CH_LC_X || c == CH_UC_X;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic s, input bit counted);
        if (tx_idle_en && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        start_req <= s;
        do
            @(posedge clk);
        while (!in_ready);
        if (counted)
            parsed_chars++;
    endtask

    task automatic send_word(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], i == 0, 1'b1);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_sizes.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_string();
        int radix_pick;
        int n_digits;
        int n_suffix;
        int i;
        int r;
        logic [7:0] c;
        bit first;
        bit abandon;
        radix_pick = $urandom_range(0, 2);
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
        n_suffix = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        abandon = ($urandom_range(0, 15) == 0);
        first = 1'b1;
        if (radix_pick != 0)
        begin
            send_char(CH_ZERO, 1'b1, 1'b1);
            first = 1'b0;
            if (radix_pick == 2)
                send_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X, 1'b0, 1'b1);
        end
        for (i = 0; i < n_digits; i++)
        begin
            if (radix_pick == 2)
            begin
                r = $urandom_range(0, 21);
                c = (r < 10) ? CH_ZERO + 8'(r) : (r < 16) ? CH_LC_A + 8'(r - 10)
                    : CH_UC_A + 8'(r - 16);
            end
            else if (first)
                c = CH_ZERO + 8'($urandom_range(1, 9));
            else
                c = CH_ZERO + 8'($urandom_range(0, 9));
            send_char(c, first, 1'b1);
            first = 1'b0;
        end
        for (i = 0; i < n_suffix; i++)
        begin
            r = $urandom_range(0, 3);
            c = (r == 0) ? CH_UC_K : (r == 1) ? CH_LC_K : (r == 2) ? CH_UC_M : CH_LC_M;
            send_char(c, first, 1'b1);
            first = 1'b0;
        end
        if (abandon && !first)
            return;
        do
            c = 8'($urandom_range(0, 255));
        while (continues_parse(c));
        send_char(c, first, 1'b1);
        if ($urandom_range(0, 7) == 0)
            send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    initial
    begin
        int n;
        bit hold_done;
        bit drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings covering the prefixes, suffixes and early endings.
        send_char(CH_UC_A, 1'b0, 1'b0);
        send_word("0");
        send_char(8'h00, 1'b0, 1'b1);
        send_word("0x");
        send_char(",", 1'b0, 1'b1);
        send_word("0XfF");
        send_char("g", 1'b0, 1'b1);
        send_word("12k");
        send_char("5", 1'b0, 1'b1);
        send_word("17a");
        send_word("089Mm");
        send_char(8'hFF, 1'b0, 1'b1);
        send_word("5");
        send_word("Z");

        while (parsed_chars < ITEM_TARGET)
        begin
            if (!hold_done && parsed_chars >= 400)
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && parsed_chars >= 900)
            begin
                wait_for_results();
                drain_done = 1'b1;
            end
            tx_idle_en = !(parsed_chars >= 1100 && parsed_chars < 1400);
            rx_idle_en = tx_idle_en;
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
            else
                send_random_string();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_sizes.size() == 0)
            $display("PASS size_string_parser");
        else
            $display("FAIL size_string_parser");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/szp_pkg.sv
rtl/core/size_string_parser.sv
sim/testbench.sv
